// ----- rtl/checker_pattern_generator_unit_assert.svh -----
// Assertion macros used by the checker module cpg_checker.
`ifndef CHECKER_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define CHECKER_PATTERN_GENERATOR_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define CPG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("checker pattern generator assertion failed");

// Checked on every clock edge, reset included.
`define CPG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("checker pattern generator reset assertion failed");

`endif

// ----- rtl/cpg_pkg.sv -----
`default_nettype none

package cpg_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int CNT_W    = $clog2(MAX_DIM);
  localparam int CFG_W    = 13;
  localparam int COLOR_W  = 32;
  localparam int DATA_W   = 32;
  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

  typedef enum logic [ADDR_W-3:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CELLS_ACROSS = 3'd2,
    REG_CELLS_DOWN   = 3'd3,
    REG_COLOR_A      = 3'd4,
    REG_COLOR_B      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]   image_width;
    logic [CFG_W-1:0]   image_height;
    logic [CFG_W-1:0]   cells_across;
    logic [CFG_W-1:0]   cells_down;
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/cpg_regs.sv -----
`default_nettype none

module cpg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cpg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cpg_pkg::DATA_W-1:0] pwdata,
  output logic      [cpg_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output cpg_pkg::cfg_t                   cfg
);
  import cpg_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= CFG_W'(256);
      cfg_r.image_height <= CFG_W'(256);
      cfg_r.cells_across <= CFG_W'(8);
      cfg_r.cells_down   <= CFG_W'(8);
      cfg_r.color_a      <= 32'hFFFF_FFFF;
      cfg_r.color_b      <= 32'h0000_00FF;
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= pwdata[CFG_W-1:0];
        REG_CELLS_ACROSS: cfg_r.cells_across <= pwdata[CFG_W-1:0];
        REG_CELLS_DOWN:   cfg_r.cells_down   <= pwdata[CFG_W-1:0];
        REG_COLOR_A:      cfg_r.color_a      <= pwdata[COLOR_W-1:0];
        REG_COLOR_B:      cfg_r.color_b      <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_r.image_height);
      REG_CELLS_ACROSS: prdata = DATA_W'(cfg_r.cells_across);
      REG_CELLS_DOWN:   prdata = DATA_W'(cfg_r.cells_down);
      REG_COLOR_A:      prdata = DATA_W'(cfg_r.color_a);
      REG_COLOR_B:      prdata = DATA_W'(cfg_r.color_b);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/checker_pattern_generator_unit.sv -----
// Checkerboard pattern source, one RGBA pixel per accepted request beat.
// The pixel appears on the output in the cycle after its request beat.
// Throughput: one pixel per cycle while out_ready stays high; a request is taken in the same cycle that
// the waiting pixel leaves, since in_ready follows out_ready when full.
// Reset (synchronous, active low) returns to the first pixel of the frame
// and loads the default register values; the output register empties.
`default_nettype none

module checker_pattern_generator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_pixel_request,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [7:0]                 out_red,
  output logic      [7:0]                 out_green,
  output logic      [7:0]                 out_blue,
  output logic      [7:0]                 out_alpha,
  output logic                            out_row_end,
  output logic                            out_frame_end,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cpg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cpg_pkg::DATA_W-1:0] pwdata,
  output logic      [cpg_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import cpg_pkg::*;

  localparam int EXT_W = DIM_W + CFG_W;

  cfg_t cfg;

  cpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (EXT_W'(v) > EXT_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // Adds the clamped cell count and takes the size off once on overflow.
  // Bit DIM_W of the result is the parity flip.
  function automatic logic [DIM_W:0] acc_step(input logic [DIM_W-1:0] err,
                                              input logic [CFG_W-1:0] cells,
                                              input logic [DIM_W-1:0] size);
    logic [DIM_W:0] n;
    logic [DIM_W:0] sum;
    logic [DIM_W:0] r;
    n   = (EXT_W'(cells) > EXT_W'(size)) ? {1'b0, size} : (DIM_W + 1)'(cells);
    sum = {1'b0, err} + n;
    if (sum >= {1'b0, size}) begin
      r = {1'b1, DIM_W'(sum - {1'b0, size})};
    end else begin
      r = {1'b0, sum[DIM_W-1:0]};
    end
    return r;
  endfunction

  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [DIM_W-1:0] col_err_r, col_err_nxt;
  logic [DIM_W-1:0] row_err_r, row_err_nxt;
  logic             col_par_r, col_par_nxt;
  logic             row_par_r, row_par_nxt;

  logic             out_valid_r;
  logic [7:0]       red_r, green_r, blue_r, alpha_r;
  logic             row_end_r, frame_end_r;

  logic [DIM_W-1:0] w, h;
  logic             row_last, frame_last;
  logic [COLOR_W-1:0] color;
  logic [DIM_W:0]   col_acc, row_acc;
  logic             take;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready && in_pixel_request;

  assign w          = clamp_dim(cfg.image_width);
  assign h          = clamp_dim(cfg.image_height);
  assign row_last   = DIM_W'(col_cnt_r) >= (w - DIM_W'(1));
  assign frame_last = row_last && (DIM_W'(row_cnt_r) >= (h - DIM_W'(1)));
  assign color      = (col_par_r ^ row_par_r) ? cfg.color_b : cfg.color_a;
  assign col_acc    = acc_step(col_err_r, cfg.cells_across, w);
  assign row_acc    = acc_step(row_err_r, cfg.cells_down, h);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    col_err_nxt = col_err_r;
    row_err_nxt = row_err_r;
    col_par_nxt = col_par_r;
    row_par_nxt = row_par_r;
    if (frame_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
      col_err_nxt = '0;
      row_err_nxt = '0;
      col_par_nxt = 1'b0;
      row_par_nxt = 1'b0;
    end else if (row_last) begin
      col_cnt_nxt = '0;
      col_err_nxt = '0;
      col_par_nxt = 1'b0;
      row_cnt_nxt = row_cnt_r + CNT_W'(1);
      row_err_nxt = row_acc[DIM_W-1:0];
      row_par_nxt = row_par_r ^ row_acc[DIM_W];
    end else begin
      col_cnt_nxt = col_cnt_r + CNT_W'(1);
      col_err_nxt = col_acc[DIM_W-1:0];
      col_par_nxt = col_par_r ^ col_acc[DIM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      col_err_r   <= '0;
      row_err_r   <= '0;
      col_par_r   <= 1'b0;
      row_par_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        col_cnt_r   <= col_cnt_nxt;
        row_cnt_r   <= row_cnt_nxt;
        col_err_r   <= col_err_nxt;
        row_err_r   <= row_err_nxt;
        col_par_r   <= col_par_nxt;
        row_par_r   <= row_par_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload needs no reset; it is only looked at while out_valid is high.
  always_ff @(posedge clk) begin
    if (take) begin
      red_r       <= color[31:24];
      green_r     <= color[23:16];
      blue_r      <= color[15:8];
      alpha_r     <= color[7:0];
      row_end_r   <= row_last;
      frame_end_r <= frame_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_alpha     = alpha_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

endmodule

`default_nettype wire

// ----- rtl/cpg_checker.sv -----
`default_nettype none

`include "checker_pattern_generator_unit_assert.svh"

module cpg_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_pixel_request,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] out_alpha,
  input wire logic       out_row_end,
  input wire logic       out_frame_end
);

  logic [33:0] out_payload;

  assign out_payload = {out_red, out_green, out_blue, out_alpha, out_row_end, out_frame_end};

  // A waiting pixel beat holds its payload.
  `CPG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload))

  // The last pixel of a frame is always the last of its row.
  `CPG_ASSERT(a_frame_row, out_valid && out_frame_end |-> out_row_end)

  // The input side never waits while the output register is free.
  `CPG_ASSERT(a_ready_free, !out_valid || out_ready |-> in_ready)

  // Each request beat yields a pixel beat in the next cycle.
  `CPG_ASSERT(a_req_out, in_valid && in_ready && in_pixel_request |=> out_valid)

  // Reset empties the output register.
  `CPG_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)

endmodule

bind checker_pattern_generator_unit cpg_checker u_cpg_checker (.*);

`default_nettype wire
